// ----- src/css_pkg.sv -----
// ----------------------------------------------------------------------------
// css_pkg: shared definitions for the cursor sequence store
// Opcodes, status codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package css_pkg;

   localparam int DEFAULT_STORE_DEPTH = 32;
   localparam int DEFAULT_DATA_WIDTH  = 32;
   localparam int OPCODE_WIDTH        = 3;
   localparam int VALUE_WIDTH         = 32;

   localparam logic [OPCODE_WIDTH-1:0] OPC_START   = 3'd0;
   localparam logic [OPCODE_WIDTH-1:0] OPC_ADVANCE = 3'd1;
   localparam logic [OPCODE_WIDTH-1:0] OPC_INSERT  = 3'd2;
   localparam logic [OPCODE_WIDTH-1:0] OPC_ATTACH  = 3'd3;
   localparam logic [OPCODE_WIDTH-1:0] OPC_REMOVE  = 3'd4;
   localparam logic [OPCODE_WIDTH-1:0] OPC_QUERY   = 3'd5;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_FULL    = 2'd1,
      ST_NO_ITEM = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_START,
      ACT_ADVANCE,
      ACT_INSERT,
      ACT_ATTACH,
      ACT_REMOVE
   } action_type;

   typedef struct packed {
      logic       load;
      action_type action;
      status_type status;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic on_item;
   } dp_stat_type;

endpackage

`default_nettype wire

// ----- src/css_ctrl.sv -----
// ----------------------------------------------------------------------------
// css_ctrl: handshake and decode controller
// Tracks whether a result beat is pending, decides when a request beat is
// taken and turns the opcode into a datapath action and a status code.
// ----------------------------------------------------------------------------
`default_nettype none

module css_ctrl (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [css_pkg::OPCODE_WIDTH-1:0]    req_opcode,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   input  css_pkg::dp_stat_type                dp_stat,
   output css_pkg::dp_cmd_type                 dp_cmd
);

   typedef enum logic {
      S_IDLE,
      S_HOLD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign rsp_valid = (state_ff == S_HOLD);
   assign req_ready = (state_ff == S_IDLE) || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      dp_cmd.load   = accept;
      dp_cmd.action = css_pkg::ACT_NONE;
      dp_cmd.status = css_pkg::ST_DONE;
      case (req_opcode)
         css_pkg::OPC_START: begin
            dp_cmd.action = css_pkg::ACT_START;
         end
         css_pkg::OPC_ADVANCE: begin
            if (dp_stat.on_item) begin
               dp_cmd.action = css_pkg::ACT_ADVANCE;
            end else begin
               dp_cmd.status = css_pkg::ST_NO_ITEM;
            end
         end
         css_pkg::OPC_INSERT: begin
            if (dp_stat.full) begin
               dp_cmd.status = css_pkg::ST_FULL;
            end else begin
               dp_cmd.action = css_pkg::ACT_INSERT;
            end
         end
         css_pkg::OPC_ATTACH: begin
            if (dp_stat.full) begin
               dp_cmd.status = css_pkg::ST_FULL;
            end else begin
               dp_cmd.action = css_pkg::ACT_ATTACH;
            end
         end
         css_pkg::OPC_REMOVE: begin
            if (dp_stat.on_item) begin
               dp_cmd.action = css_pkg::ACT_REMOVE;
            end else begin
               dp_cmd.status = css_pkg::ST_NO_ITEM;
            end
         end
         default: begin
            dp_cmd.action = css_pkg::ACT_NONE;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = S_HOLD;
      end else if (rsp_ready) begin
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/css_datapath.sv -----
// ----------------------------------------------------------------------------
// css_datapath: shifting register store, count, cursor and result register
// Applies one action per load: opens or closes a slot across the whole
// store at once, moves the cursor and captures the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module css_datapath #(
   parameter int STORE_DEPTH = css_pkg::DEFAULT_STORE_DEPTH,
   parameter int DATA_WIDTH  = css_pkg::DEFAULT_DATA_WIDTH,
   parameter int CW          = $clog2(STORE_DEPTH + 1)
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  css_pkg::dp_cmd_type                 dp_cmd,
   output css_pkg::dp_stat_type                dp_stat,
   input  wire  [css_pkg::VALUE_WIDTH-1:0]     entry_value,
   output logic [css_pkg::VALUE_WIDTH-1:0]     current_value,
   output logic                                has_current,
   output logic [CW-1:0]                       item_count,
   output logic [CW-1:0]                       cursor_position,
   output logic [1:0]                          status
);

   localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

   logic [DATA_WIDTH-1:0] store_ff [STORE_DEPTH];
   logic [DATA_WIDTH-1:0] store_in [STORE_DEPTH];
   logic [CW-1:0]         total_ff, total_in;
   logic [CW-1:0]         cursor_ff, cursor_in;
   logic [CW-1:0]         pos;

   logic [css_pkg::VALUE_WIDTH-1:0] value_ff;
   logic                            has_ff;
   css_pkg::status_type             status_ff;

   logic [DATA_WIDTH+css_pkg::VALUE_WIDTH-1:0] entry_wide;
   logic [DATA_WIDTH-1:0]                      entry_fit;
   logic [DATA_WIDTH+css_pkg::VALUE_WIDTH-1:0] read_wide;
   logic                                       has_in;
   logic [DATA_WIDTH-1:0]                      read_word;

   assign entry_wide = {{DATA_WIDTH{1'b0}}, entry_value};
   assign entry_fit  = entry_wide[DATA_WIDTH-1:0];

   assign dp_stat.on_item = (cursor_ff < total_ff);
   assign dp_stat.full    = (total_ff >= DEPTH_C);

   always_comb begin
      total_in  = total_ff;
      cursor_in = cursor_ff;
      pos       = cursor_ff;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         store_in[i] = store_ff[i];
      end
      case (dp_cmd.action)
         css_pkg::ACT_START: begin
            cursor_in = '0;
         end
         css_pkg::ACT_ADVANCE: begin
            cursor_in = cursor_ff + CW'(1);
         end
         css_pkg::ACT_INSERT, css_pkg::ACT_ATTACH: begin
            if (dp_cmd.action == css_pkg::ACT_INSERT) begin
               pos = dp_stat.on_item ? cursor_ff : '0;
            end else begin
               pos = dp_stat.on_item ? (cursor_ff + CW'(1)) : total_ff;
            end
            cursor_in = pos;
            total_in  = total_ff + CW'(1);
            for (int i = 1; i < STORE_DEPTH; i++) begin
               if (CW'(i) > pos) begin
                  store_in[i] = store_ff[i-1];
               end
            end
            for (int i = 0; i < STORE_DEPTH; i++) begin
               if (CW'(i) == pos) begin
                  store_in[i] = entry_fit;
               end
            end
         end
         css_pkg::ACT_REMOVE: begin
            total_in = total_ff - CW'(1);
            for (int i = 0; i < STORE_DEPTH - 1; i++) begin
               if (CW'(i) >= cursor_ff) begin
                  store_in[i] = store_ff[i+1];
               end
            end
         end
         default: begin
            total_in = total_ff;
         end
      endcase
   end

   assign has_in    = (cursor_in < total_in);
   assign read_word = store_in[cursor_in[IW-1:0]];
   assign read_wide = {{css_pkg::VALUE_WIDTH{1'b0}}, read_word};

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= '0;
         cursor_ff <= '0;
      end else if (dp_cmd.load) begin
         total_ff  <= total_in;
         cursor_ff <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= store_in[i];
         end
         value_ff  <= has_in ? read_wide[css_pkg::VALUE_WIDTH-1:0] : '0;
         has_ff    <= has_in;
         status_ff <= dp_cmd.status;
      end
   end

   assign current_value   = value_ff;
   assign has_current     = has_ff;
   assign item_count      = total_ff;
   assign cursor_position = cursor_ff;
   assign status          = status_ff;

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= total_ff)
      else $error("cursor beyond item count");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= DEPTH_C)
      else $error("item count beyond store depth");

   a_refused_hold: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load && dp_cmd.status != css_pkg::ST_DONE |=>
         $stable(total_ff) && $stable(cursor_ff))
      else $error("refused beat changed the store");

   a_insert_grow: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load && (dp_cmd.action == css_pkg::ACT_INSERT ||
                      dp_cmd.action == css_pkg::ACT_ATTACH) |=>
         total_ff == $past(total_ff) + CW'(1) && has_ff)
      else $error("insert did not add a current item");

endmodule

`default_nettype wire

// ----- src/cursor_sequence_store_top.sv -----
// ----------------------------------------------------------------------------
// cursor_sequence_store_top: ordered word store with a cursor
// Each request beat carries an opcode (start, advance, insert, attach,
// remove, query) and a value; each yields exactly one response beat with
// the current word, a has-current flag, the item count, the cursor and a
// status (done, refused full, refused no current item).
// Request and response channels use valid/ready. A request beat is applied
// in the cycle it is taken: the whole register store shifts at once and the
// result is registered, so the response beat is valid in the cycle after the
// request beat. Throughput is one beat per cycle while the receiver takes
// each response, set by the register store shift and the cursor read mux.
// While a response beat waits, a new request is taken only in a cycle where
// the response is taken too; if the receiver stalls, the request channel
// stalls with it and the pending response holds unchanged.
// Reset clears the count and the cursor and drops any pending response;
// stored words are not cleared and are read only after being written.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_sequence_store_top #(
   parameter int STORE_DEPTH = css_pkg::DEFAULT_STORE_DEPTH,
   parameter int DATA_WIDTH  = css_pkg::DEFAULT_DATA_WIDTH
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  [css_pkg::OPCODE_WIDTH-1:0]      req_opcode,
   input  wire  [css_pkg::VALUE_WIDTH-1:0]       req_entry_value,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic [css_pkg::VALUE_WIDTH-1:0]       rsp_current_value,
   output logic                                  rsp_has_current,
   output logic [$clog2(STORE_DEPTH+1)-1:0]      rsp_item_count,
   output logic [$clog2(STORE_DEPTH+1)-1:0]      rsp_cursor_position,
   output logic [1:0]                            rsp_status
);

   css_pkg::dp_cmd_type  dp_cmd;
   css_pkg::dp_stat_type dp_stat;

   css_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .dp_stat    (dp_stat),
      .dp_cmd     (dp_cmd)
   );

   css_datapath #(
      .STORE_DEPTH (STORE_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH),
      .CW          ($clog2(STORE_DEPTH + 1))
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .dp_cmd          (dp_cmd),
      .dp_stat         (dp_stat),
      .entry_value     (req_entry_value),
      .current_value   (rsp_current_value),
      .has_current     (rsp_has_current),
      .item_count      (rsp_item_count),
      .cursor_position (rsp_cursor_position),
      .status          (rsp_status)
   );

endmodule

`default_nettype wire
